>>> hdl/one_pole_envelope_generator_core_defines.svh
// Assertion macros of the envelope generator RTL.
`ifndef ONE_POLE_ENVELOPE_GENERATOR_CORE_DEFINES_SVH
`define ONE_POLE_ENVELOPE_GENERATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define OPEG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("opeg assertion failed");

// Check a property on every rising clock edge, reset included.
`define OPEG_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("opeg assertion failed");

`else

`define OPEG_ASSERT(lbl, clk, rst, prop)
`define OPEG_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hdl/opeg_pkg.sv
// Types, constants and helpers of the one-pole envelope generator.
package opeg_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE                = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_RATE         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_RATE          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN_LEVEL       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_RATE        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMON_RATE_OFFSET  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_RATE_OFFSET  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_RATE_OFFSET = 3'd7;

   localparam logic [1:0] MODE_AR  = 2'd1;
   localparam logic [1:0] MODE_LIN = 2'd2;

   localparam logic [15:0] FULL_SCALE         = 16'd65535;
   localparam logic [15:0] LOW_LEVEL          = 16'd655;
   localparam logic [15:0] ATTACK_TOP         = 16'd58982;
   localparam logic [15:0] LINEAR_TOP         = 16'd62259;
   localparam logic [16:0] SUSTAIN_MARGIN     = 17'd655;
   localparam logic [16:0] LINEAR_ATTACK_STEP = 17'd66;

   // Rate sum at which the coefficient reaches its 0.99 cap (64880 * 10).
   localparam int               DIVIDEND_W  = 20;
   localparam logic signed [25:0] SUM_CAP    = 26'sd648800;
   localparam logic signed [25:0] RATE_MAX   = 26'sd16777215;
   localparam logic [4:0]        DIV_BASE    = 5'd10;
   localparam int               MAC_STEPS   = 16;
   localparam int               STEP_CNT_W  = $clog2(MAC_STEPS);
   localparam int               PRODUCT_W   = 34;

   typedef enum logic [1:0] {
      STG_OFF     = 2'd0,
      STG_ATTACK  = 2'd1,
      STG_DECAY   = 2'd2,
      STG_RELEASE = 2'd3
   } stage_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [23:0]        attack_rate;
      logic [23:0]        decay_rate;
      logic [15:0]        sustain_level;
      logic [23:0]        release_rate;
      logic signed [23:0] common_rate_offset;
      logic signed [23:0] attack_rate_offset;
      logic signed [23:0] release_rate_offset;
   } cfg_type;

   typedef struct packed {
      stage_type          stage;
      logic [15:0]        target;
      logic signed [24:0] rate;
      logic               one_shot;
      logic               linear;
      logic [15:0]        level_lin;
   } tick_type;

   // Rate plus offset, saturated at the top of the unsigned Q8.16 range.
   function automatic logic signed [24:0] sat_rate(input logic [23:0] r,
                                                    input logic signed [23:0] off);
      logic signed [25:0] s;
      s = signed'({2'b00, r}) + {{2{off[23]}}, off};
      if (s > RATE_MAX) begin
         return RATE_MAX[24:0];
      end
      return s[24:0];
   endfunction

endpackage

>>> hdl/opeg_req_if.sv
// Tick request channel: start and arm flags.
interface opeg_req_if;
   logic valid;
   logic ready;
   logic start_attack;
   logic arm_one_shot;
   modport source (output valid, start_attack, arm_one_shot, input ready);
   modport sink (input valid, start_attack, arm_one_shot, output ready);
endinterface

>>> hdl/opeg_rsp_if.sv
// Tick response channel: level and stage after the tick.
interface opeg_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] level;
   logic [1:0]  stage_now;
   modport source (output valid, level, stage_now, input ready);
   modport sink (input valid, level, stage_now, output ready);
endinterface

>>> hdl/opeg_csr_if.sv
// Register write channel: index and data.
interface opeg_csr_if;
   logic                             valid;
   logic                             ready;
   logic [opeg_pkg::CSR_INDEX_W-1:0] index;
   logic [opeg_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/one_pole_envelope_generator_core.sv
// One-pole envelope generator: one tick per request beat, one response beat per tick.
// Each request beat is one tick of the envelope. A one-pole tick passes the stage logic as
// the request is accepted, forms the coefficient dividend and the level difference in S_LOAD,
// runs the bit-serial unit that divides the rate sum by ten and multiplies the difference by
// the quotient one bit per cycle, writes the new level, and then waits in S_DONE until the
// output register is free before the response beat shows valid. A linear-attack tick in
// mode 2 skips the serial unit. The next request beat is taken once the previous tick is done,
// even while its response still waits for rsp_bus.ready. Register writes go through csr_bus
// at any time and take effect on the next tick; write them only between ticks.
`include "one_pole_envelope_generator_core_defines.svh"

module one_pole_envelope_generator_core (
   input  logic       clock,
   input  logic       reset,
   opeg_req_if.sink   req_bus,
   opeg_rsp_if.source rsp_bus,
   opeg_csr_if.sink   csr_bus
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOAD = 4'b0010,
      S_RUN  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   opeg_pkg::cfg_type         cfg;
   opeg_pkg::tick_type        tick;
   logic [15:0]               level_ff, level_in;
   opeg_pkg::stage_type       stage_ff, stage_in;
   logic [15:0]               target_ff, target_in;
   logic signed [24:0]        rate_ff, rate_in;
   logic                      one_shot_ff, one_shot_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               rsp_level_ff, rsp_level_in;
   logic [1:0]                rsp_stage_ff, rsp_stage_in;
   logic                      req_fire;
   logic                      rsp_free;
   logic signed [25:0]        rate_sum;
   logic [opeg_pkg::DIVIDEND_W-1:0]       dividend;
   logic signed [16:0]                    diff;
   logic                                  mac_start;
   logic                                  mac_done;
   logic signed [opeg_pkg::PRODUCT_W-1:0] product;
   logic signed [17:0]                    delta;
   logic signed [18:0]                    level_sum;
   logic [15:0]                           level_new;

   opeg_csr_regs u_csr_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   opeg_stage_sel u_stage_sel (
      .cfg          (cfg),
      .start_attack (req_bus.start_attack),
      .arm_one_shot (req_bus.arm_one_shot),
      .level        (level_ff),
      .stage        (stage_ff),
      .target       (target_ff),
      .rate         (rate_ff),
      .one_shot     (one_shot_ff),
      .tick         (tick)
   );

   opeg_serial_mac u_serial_mac (
      .clock    (clock),
      .reset    (reset),
      .start    (mac_start),
      .dividend (dividend),
      .diff     (diff),
      .done     (mac_done),
      .product  (product)
   );

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign req_fire          = req_bus.valid && (state_ff == S_IDLE);
   assign rsp_free          = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.level     = rsp_level_ff;
   assign rsp_bus.stage_now = rsp_stage_ff;

   // Coefficient dividend: zero for a non-positive sum, held at the 0.99 cap above it.
   assign rate_sum  = {rate_ff[24], rate_ff} +
                      {{2{cfg.common_rate_offset[23]}}, cfg.common_rate_offset};
   assign dividend  = (rate_sum <= 26'sd0)              ? '0 :
                      (rate_sum >= opeg_pkg::SUM_CAP)   ? opeg_pkg::SUM_CAP[19:0] :
                                                          rate_sum[19:0];
   assign diff      = signed'({1'b0, target_ff}) - signed'({1'b0, level_ff});
   assign mac_start = (state_ff == S_LOAD);

   // Arithmetic shift by 16 floors the move toward minus infinity.
   assign delta     = product[opeg_pkg::PRODUCT_W-1:16];
   assign level_sum = signed'({3'b000, level_ff}) + {delta[17], delta};
   assign level_new = level_sum[18]           ? 16'd0 :
                      (level_sum[17:16] != 0) ? opeg_pkg::FULL_SCALE :
                                                level_sum[15:0];

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      stage_in     = stage_ff;
      target_in    = target_ff;
      rate_in      = rate_ff;
      one_shot_in  = one_shot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_level_in = rsp_level_ff;
      rsp_stage_in = rsp_stage_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               stage_in    = tick.stage;
               target_in   = tick.target;
               rate_in     = tick.rate;
               one_shot_in = tick.one_shot;
               if (tick.linear) begin
                  level_in = tick.level_lin;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            state_in = S_RUN;
         end
         S_RUN: begin
            if (mac_done) begin
               level_in = level_new;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold the finished tick until the output register frees up.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_stage_in = stage_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         stage_ff     <= opeg_pkg::STG_OFF;
         target_ff    <= '0;
         rate_ff      <= '0;
         one_shot_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         stage_ff     <= stage_in;
         target_ff    <= target_in;
         rate_ff      <= rate_in;
         one_shot_ff  <= one_shot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_level_ff <= rsp_level_in;
      rsp_stage_ff <= rsp_stage_in;
   end

   `OPEG_ASSERT(a_load_then_run, clock, reset, (state_ff == S_LOAD) |=> (state_ff == S_RUN))
   `OPEG_ASSERT(a_mac_done_in_run, clock, reset, mac_done |-> (state_ff == S_RUN))
   `OPEG_ASSERT(a_done_to_rsp, clock, reset, ((state_ff == S_DONE) && rsp_free) |=> rsp_valid_ff)
   `OPEG_ASSERT_ALWAYS(a_reset_clears_rsp, clock, $past(reset) |-> !rsp_valid_ff)

endmodule

>>> hdl/opeg_csr_regs.sv
// Configuration register file of the envelope generator.
module opeg_csr_regs (
   input  logic              clock,
   input  logic              reset,
   opeg_csr_if.sink          csr_bus,
   output opeg_pkg::cfg_type cfg
);

   opeg_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            opeg_pkg::CSR_MODE:                cfg_in.mode = csr_bus.data[1:0];
            opeg_pkg::CSR_ATTACK_RATE:         cfg_in.attack_rate = csr_bus.data;
            opeg_pkg::CSR_DECAY_RATE:          cfg_in.decay_rate = csr_bus.data;
            opeg_pkg::CSR_SUSTAIN_LEVEL:       cfg_in.sustain_level = csr_bus.data[15:0];
            opeg_pkg::CSR_RELEASE_RATE:        cfg_in.release_rate = csr_bus.data;
            opeg_pkg::CSR_COMMON_RATE_OFFSET:  cfg_in.common_rate_offset = csr_bus.data;
            opeg_pkg::CSR_ATTACK_RATE_OFFSET:  cfg_in.attack_rate_offset = csr_bus.data;
            opeg_pkg::CSR_RELEASE_RATE_OFFSET: cfg_in.release_rate_offset = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/opeg_stage_sel.sv
// Stage logic of one tick: flags, next stage, target and rate.
module opeg_stage_sel (
   input  opeg_pkg::cfg_type   cfg,
   input  logic                start_attack,
   input  logic                arm_one_shot,
   input  logic [15:0]         level,
   input  opeg_pkg::stage_type stage,
   input  logic [15:0]         target,
   input  logic signed [24:0]  rate,
   input  logic                one_shot,
   output opeg_pkg::tick_type  tick
);

   logic [16:0] lin_sum;
   logic [16:0] sustain_top;

   assign lin_sum     = {1'b0, level} + opeg_pkg::LINEAR_ATTACK_STEP;
   assign sustain_top = {1'b0, cfg.sustain_level} + opeg_pkg::SUSTAIN_MARGIN;

   always_comb begin
      tick.stage     = stage;
      tick.target    = target;
      tick.rate      = rate;
      tick.one_shot  = one_shot;
      tick.linear    = 1'b0;
      tick.level_lin = lin_sum[16] ? opeg_pkg::FULL_SCALE : lin_sum[15:0];

      if (start_attack) begin
         tick.stage    = opeg_pkg::STG_ATTACK;
         tick.one_shot = 1'b0;
      end
      if (arm_one_shot) begin
         tick.one_shot = 1'b1;
      end
      if (level <= opeg_pkg::LOW_LEVEL) begin
         tick.one_shot = 1'b0;
      end

      if (cfg.mode == opeg_pkg::MODE_AR) begin
         if (tick.stage == opeg_pkg::STG_ATTACK) begin
            tick.target = opeg_pkg::FULL_SCALE;
            tick.rate   = opeg_pkg::sat_rate(cfg.attack_rate, cfg.attack_rate_offset);
            if (tick.one_shot && level > opeg_pkg::ATTACK_TOP) begin
               tick.stage = opeg_pkg::STG_RELEASE;
            end
         end
         if (tick.stage == opeg_pkg::STG_RELEASE) begin
            tick.target = '0;
            tick.rate   = opeg_pkg::sat_rate(cfg.release_rate, cfg.release_rate_offset);
         end
      end else if (cfg.mode == opeg_pkg::MODE_LIN) begin
         if (tick.stage == opeg_pkg::STG_ATTACK) begin
            // Linear ramp replaces the one-pole move on this tick.
            tick.linear = 1'b1;
            tick.rate   = opeg_pkg::sat_rate(cfg.attack_rate, cfg.attack_rate_offset);
            if (tick.level_lin > opeg_pkg::LINEAR_TOP) begin
               tick.stage = opeg_pkg::STG_RELEASE;
            end
         end else if (tick.stage == opeg_pkg::STG_RELEASE) begin
            tick.target = '0;
            tick.rate   = opeg_pkg::sat_rate(cfg.release_rate, cfg.release_rate_offset);
         end
      end else begin
         if (tick.stage == opeg_pkg::STG_ATTACK) begin
            tick.target = opeg_pkg::FULL_SCALE;
            tick.rate   = signed'({1'b0, cfg.attack_rate});
            if (level > opeg_pkg::ATTACK_TOP) begin
               tick.stage = opeg_pkg::STG_DECAY;
            end
         end
         if (tick.stage == opeg_pkg::STG_DECAY) begin
            tick.target = cfg.sustain_level;
            tick.rate   = signed'({1'b0, cfg.decay_rate});
            if (tick.one_shot && {1'b0, level} <= sustain_top) begin
               tick.stage = opeg_pkg::STG_RELEASE;
            end
         end
         if (tick.stage == opeg_pkg::STG_RELEASE) begin
            tick.target = '0;
            tick.rate   = signed'({1'b0, cfg.release_rate});
         end
      end
   end

endmodule

>>> hdl/opeg_serial_mac.sv
// Bit-serial divide by ten fused with an MSB-first multiply of the difference.
module opeg_serial_mac (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [opeg_pkg::DIVIDEND_W-1:0]             dividend,
   input  logic signed [16:0]                          diff,
   output logic                                        done,
   output logic signed [opeg_pkg::PRODUCT_W-1:0]       product
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [opeg_pkg::STEP_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [3:0]                            rem_ff, rem_in;
   logic [opeg_pkg::MAC_STEPS-1:0]        num_sr_ff, num_sr_in;
   logic signed [16:0]                    diff_ff, diff_in;
   logic signed [opeg_pkg::PRODUCT_W-1:0] acc_ff, acc_in;
   logic [4:0]                            rem_sh;
   logic                                  qbit;
   logic [4:0]                            rem_sub;

   assign done    = done_ff;
   assign product = acc_ff;

   // One quotient bit per cycle; the remainder stays below ten.
   assign rem_sh  = {rem_ff, num_sr_ff[opeg_pkg::MAC_STEPS-1]};
   assign qbit    = (rem_sh >= opeg_pkg::DIV_BASE);
   assign rem_sub = rem_sh - opeg_pkg::DIV_BASE;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      num_sr_in = num_sr_ff;
      diff_in   = diff_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         rem_in    = dividend[opeg_pkg::DIVIDEND_W-1:opeg_pkg::MAC_STEPS];
         num_sr_in = dividend[opeg_pkg::MAC_STEPS-1:0];
         diff_in   = diff;
         acc_in    = '0;
      end else if (busy_ff) begin
         rem_in    = qbit ? rem_sub[3:0] : rem_sh[3:0];
         num_sr_in = num_sr_ff << 1;
         // Horner step: double, then add the difference on a set quotient bit.
         acc_in    = (acc_ff <<< 1) +
                     (qbit ? {{(opeg_pkg::PRODUCT_W-17){diff_ff[16]}}, diff_ff}
                           : {opeg_pkg::PRODUCT_W{1'b0}});
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == opeg_pkg::STEP_CNT_W'(opeg_pkg::MAC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff    <= rem_in;
      num_sr_ff <= num_sr_in;
      diff_ff   <= diff_in;
      acc_ff    <= acc_in;
   end

endmodule

>>> test/one_pole_envelope_generator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the one-pole envelope generator core: ticks against a predictor.
module one_pole_envelope_generator_core_tb;
   import opeg_pkg::*;

   localparam logic [1:0] MODE_ADSR_ALT = 2'd3;
   localparam int COEF_CAP     = 64880;
   localparam int TICK_TARGET  = 650;
   localparam int CALM_AFTER   = 560;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 10;
   localparam int PLAN_LEN     = 30;

   typedef struct packed {
      logic [15:0] level;
      stage_type   stage;
   } envelope_out_t;

   typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_TICK_TYPED} row_kind_t;

   typedef struct packed {
      row_kind_t               kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   data;
      logic                    start;
      logic                    arm;
      logic [15:0]             level;
      stage_type               stage;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   opeg_req_if req_bus ();
   opeg_rsp_if rsp_bus ();
   opeg_csr_if csr_bus ();

   one_pole_envelope_generator_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   // Shadow copy of the envelope state and its registers.
   cfg_type   shadow_cfg = '0;
   int        shadow_level = 0;
   int        shadow_target = 0;
   int        shadow_rate = 0;
   stage_type shadow_stage = STG_OFF;
   bit        shadow_armed = 1'b0;

   envelope_out_t levels_due[$];
   int ticks_sent = 0;
   int levels_checked = 0;
   int reg_writes = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   plan_row_t directed_plan [PLAN_LEN] = '{
      '{ROW_TICK_TYPED, '0, '0, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK_TYPED, '0, '0, 1'b1, 1'b1, 16'd0, STG_ATTACK},
      '{ROW_WRITE, CSR_ATTACK_RATE, 24'hFFFFFF, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK_TYPED, '0, '0, 1'b0, 1'b0, 16'd64879, STG_ATTACK},
      '{ROW_TICK_TYPED, '0, '0, 1'b0, 1'b1, 16'd64879, STG_DECAY},
      '{ROW_WRITE, CSR_DECAY_RATE, 24'hFFFFFF, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_WRITE, CSR_SUSTAIN_LEVEL, 24'h00FFFF, 1'b0, 1'b0, 16'd0, STG_OFF},
      // sustain plus margin runs past full scale, so the armed decay releases at once
      '{ROW_TICK_TYPED, '0, '0, 1'b0, 1'b0, 16'd64879, STG_RELEASE},
      '{ROW_WRITE, CSR_RELEASE_RATE, 24'hFFFFFF, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_WRITE, CSR_COMMON_RATE_OFFSET, 24'h800000, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b1, 1'b0, 16'd0, STG_OFF},
      '{ROW_WRITE, CSR_MODE, 24'(MODE_AR), 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_WRITE, CSR_ATTACK_RATE_OFFSET, 24'h7FFFFF, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_WRITE, CSR_RELEASE_RATE_OFFSET, 24'h800000, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_WRITE, CSR_COMMON_RATE_OFFSET, 24'h000000, 1'b0, 1'b0, 16'd0, STG_OFF},
      // saturated attack rate: four ticks pull the level to within one step of full scale
      '{ROW_TICK, '0, '0, 1'b1, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_WRITE, CSR_MODE, 24'(MODE_LIN), 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK_TYPED, '0, '0, 1'b1, 1'b0, 16'd65535, STG_RELEASE},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b1, 1'b1, 16'd0, STG_OFF},
      '{ROW_WRITE, CSR_MODE, 24'(MODE_ADSR_ALT), 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b0, 1'b0, 16'd0, STG_OFF},
      '{ROW_TICK, '0, '0, 1'b0, 1'b1, 16'd0, STG_OFF}
   };

   function automatic int capped_rate(input logic [23:0] rate, input logic signed [23:0] offset);
      longint total;
      total = longint'(rate) + longint'(offset);
      if (total > longint'(RATE_MAX)) begin
         total = longint'(RATE_MAX);
      end
      return int'(total);
   endfunction

   // Move the level one pole step toward the stored target.
   function automatic void glide_level();
      longint total;
      longint coef;
      longint gap;
      longint step;
      longint next;
      total = longint'(shadow_rate) + longint'(signed'(shadow_cfg.common_rate_offset));
      coef = 0;
      if (total > 0) begin
         coef = total / 10;
         if (coef > COEF_CAP) begin
            coef = COEF_CAP;
         end
      end
      gap = longint'(shadow_target) - longint'(shadow_level);
      // round toward minus infinity on the way down
      if (gap >= 0) begin
         step = (gap * coef) >>> 16;
      end else begin
         step = -(((-gap) * coef + 65535) >>> 16);
      end
      next = longint'(shadow_level) + step;
      if (next < 0) begin
         next = 0;
      end
      if (next > longint'(FULL_SCALE)) begin
         next = longint'(FULL_SCALE);
      end
      shadow_level = int'(next);
   endfunction

   function automatic envelope_out_t advance_envelope(input logic start, input logic arm);
      if (start) begin
         shadow_stage = STG_ATTACK;
         shadow_armed = 1'b0;
      end
      if (arm) begin
         shadow_armed = 1'b1;
      end
      if (shadow_level <= int'(LOW_LEVEL)) begin
         shadow_armed = 1'b0;
      end
      case (shadow_cfg.mode)
         MODE_AR: begin
            if (shadow_stage == STG_ATTACK) begin
               shadow_target = int'(FULL_SCALE);
               shadow_rate = capped_rate(shadow_cfg.attack_rate,
                                         shadow_cfg.attack_rate_offset);
               if (shadow_armed && shadow_level > int'(ATTACK_TOP)) begin
                  shadow_stage = STG_RELEASE;
               end
            end
            if (shadow_stage == STG_RELEASE) begin
               shadow_rate = capped_rate(shadow_cfg.release_rate,
                                         shadow_cfg.release_rate_offset);
               shadow_target = 0;
            end
            glide_level();
         end
         MODE_LIN: begin
            if (shadow_stage == STG_ATTACK) begin
               shadow_level = shadow_level + int'(LINEAR_ATTACK_STEP);
               if (shadow_level > int'(FULL_SCALE)) begin
                  shadow_level = int'(FULL_SCALE);
               end
               shadow_rate = capped_rate(shadow_cfg.attack_rate,
                                         shadow_cfg.attack_rate_offset);
               if (shadow_level > int'(LINEAR_TOP)) begin
                  shadow_stage = STG_RELEASE;
               end
            end else begin
               if (shadow_stage == STG_RELEASE) begin
                  shadow_rate = capped_rate(shadow_cfg.release_rate,
                                            shadow_cfg.release_rate_offset);
                  shadow_target = 0;
               end
               glide_level();
            end
         end
         default: begin
            // ADSR, mode three included; stage rates go in without the attack and release offsets
            if (shadow_stage == STG_ATTACK) begin
               shadow_target = int'(FULL_SCALE);
               shadow_rate = int'(shadow_cfg.attack_rate);
               if (shadow_level > int'(ATTACK_TOP)) begin
                  shadow_stage = STG_DECAY;
               end
            end
            if (shadow_stage == STG_DECAY) begin
               shadow_rate = int'(shadow_cfg.decay_rate);
               shadow_target = int'(shadow_cfg.sustain_level);
               if (shadow_armed && shadow_level <=
                   int'(shadow_cfg.sustain_level) + int'(SUSTAIN_MARGIN)) begin
                  shadow_stage = STG_RELEASE;
               end
            end
            if (shadow_stage == STG_RELEASE) begin
               shadow_rate = int'(shadow_cfg.release_rate);
               shadow_target = 0;
            end
            glide_level();
         end
      endcase
      return envelope_out_t'{16'(shadow_level), shadow_stage};
   endfunction

   function automatic logic [23:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(0, 65536));
         3: return 24'($urandom_range(65536, 648800));
         4: return 24'($urandom_range(1000, 20000));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] pick_offset();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return 24'h800000;
         2: return 24'h7FFFFF;
         3: return 24'($urandom_range(0, 131072) - 65536);
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   task automatic send_tick(input logic start, input logic arm, input bit typed,
                            input envelope_out_t typed_out);
      envelope_out_t predicted;
      csr_bus.valid <= 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.start_attack <= start;
      req_bus.arm_one_shot <= arm;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = advance_envelope(start, arm);
      levels_due.push_back(typed ? typed_out : predicted);
      ticks_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         CSR_MODE:                shadow_cfg.mode = data[1:0];
         CSR_ATTACK_RATE:         shadow_cfg.attack_rate = data;
         CSR_DECAY_RATE:          shadow_cfg.decay_rate = data;
         CSR_SUSTAIN_LEVEL:       shadow_cfg.sustain_level = data[15:0];
         CSR_RELEASE_RATE:        shadow_cfg.release_rate = data;
         CSR_COMMON_RATE_OFFSET:  shadow_cfg.common_rate_offset = data;
         CSR_ATTACK_RATE_OFFSET:  shadow_cfg.attack_rate_offset = data;
         CSR_RELEASE_RATE_OFFSET: shadow_cfg.release_rate_offset = data;
      endcase
      reg_writes++;
   endtask

   // Hold off until every tick has answered, so the block is idle.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_levels
      envelope_out_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (levels_due.size() == 0) begin
            report_mismatch($sformatf("level %0d stage %0d arrived with no tick pending",
                                      rsp_bus.level, rsp_bus.stage_now));
         end else begin
            want = levels_due.pop_front();
            if (rsp_bus.level !== want.level || rsp_bus.stage_now !== want.stage) begin
               report_mismatch($sformatf(
                  "expected level %0d stage %0d, got level %0d stage %0d",
                  want.level, want.stage, rsp_bus.level, rsp_bus.stage_now));
            end
         end
         levels_checked++;
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int phase_len;
      logic [23:0] noise;
      req_bus.valid = 1'b0;
      req_bus.start_attack = 1'b0;
      req_bus.arm_one_shot = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         case (directed_plan[i].kind)
            ROW_WRITE: begin
               settle();
               write_reg(directed_plan[i].index, directed_plan[i].data);
            end
            ROW_TICK: begin
               send_tick(directed_plan[i].start, directed_plan[i].arm, 1'b0, '0);
            end
            default: begin
               send_tick(directed_plan[i].start, directed_plan[i].arm, 1'b1,
                         envelope_out_t'{directed_plan[i].level, directed_plan[i].stage});
            end
         endcase
      end

      // Random phases: new settings, then a run of ticks that mostly starts with an attack.
      while (ticks_sent < TICK_TARGET) begin
         settle();
         noise = $urandom;
         write_reg(CSR_MODE, {noise[23:2], 2'($urandom_range(0, 3))});
         write_reg(CSR_ATTACK_RATE, pick_rate());
         write_reg(CSR_DECAY_RATE, pick_rate());
         noise = $urandom;
         case ($urandom_range(0, 3))
            0: write_reg(CSR_SUSTAIN_LEVEL, {noise[23:16], 16'h0000});
            1: write_reg(CSR_SUSTAIN_LEVEL, {noise[23:16], 16'hFFFF});
            default: write_reg(CSR_SUSTAIN_LEVEL, noise);
         endcase
         write_reg(CSR_RELEASE_RATE, pick_rate());
         write_reg(CSR_COMMON_RATE_OFFSET, pick_offset());
         write_reg(CSR_ATTACK_RATE_OFFSET, pick_offset());
         write_reg(CSR_RELEASE_RATE_OFFSET, pick_offset());
         phase_len = $urandom_range(15, 50);
         for (int k = 0; k < phase_len; k++) begin
            if (ticks_sent >= CALM_AFTER) begin
               calm = 1'b1;
            end
            send_tick((k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 29) == 0),
                      $urandom_range(0, 7) == 0, 1'b0, '0);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (levels_due.size() != 0) begin
         report_mismatch($sformatf("%0d ticks never answered", levels_due.size()));
      end
      $display("Run covered %0d ticks in all four mode codes and %0d register writes;",
               ticks_sent, reg_writes);
      $display("%0d responses compared, %0d mismatches", levels_checked, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
